@@ sv/mbd_pkg.sv @@
package mbd_pkg;

    // Default line and frame limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Configuration registers
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    // Stream field widths
    localparam int LABEL_W  = 8;
    localparam int COL_O_W  = 10;
    localparam int ROW_O_W  = 10;
    localparam int M_DATA_W = 24;

    // Label classes kept in the line buffer
    typedef logic [1:0] t_cls;
    localparam t_cls CLS_ZERO  = 2'd0;
    localparam t_cls CLS_ONE   = 2'd1;
    localparam t_cls CLS_OTHER = 2'd2;

    // One line buffer word: {class two rows back, class one row back}
    localparam int LINE_W = 4;

    // Output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = OQ_AW + 1;

    // Stage 0 -> stage 1 control and payload
    typedef struct packed {
        logic               push;
        logic               emit;
        logic               last;
        logic               on_rim;
        logic               h_one;
        t_cls               cls;
        logic [COL_O_W-1:0] col;
        logic [ROW_O_W-1:0] row;
    } t_stage;

    // One decision
    typedef struct packed {
        logic [COL_O_W-1:0] col;
        logic [ROW_O_W-1:0] row;
        logic               bnd;
        logic               last;
    } t_result;

endpackage

@@ sv/mbd_ram.sv @@
module mbd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/mbd_window.sv @@
module mbd_window #(
    parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mbd_pkg::t_stage              i_s0,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    output mbd_pkg::t_result             o_res,
    output logic                         o_res_vld,
    output logic                         o_pend
);

    import mbd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    t_stage            r_s1;
    logic [AW-1:0]     r_addr1;
    logic              r_fwd;
    logic [LINE_W-1:0] r_fwd_data;
    logic [LINE_W-1:0] ram_q;
    logic [LINE_W-1:0] rd_word;
    logic [LINE_W-1:0] wr_word;
    t_cls              up_cls;
    t_cls              mid_cls;
    t_cls              cur_cls;
    // window taps
    t_cls              r_v1;
    t_cls              r_m1;
    t_cls              r_m2;
    t_cls              r_u1;

    // Column line buffer, read at stage 0, written back at stage 1
    mbd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_s1.push),
        .i_waddr (r_addr1),
        .i_wdata (wr_word),
        .i_raddr (i_addr),
        .o_rdata (ram_q)
    );

    // Stage 1 register; a write-back that meets a read of the same column is forwarded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= '0;
            r_fwd <= 1'b0;
        end else begin
            r_s1  <= i_s0;
            r_fwd <= i_s0.push && r_s1.push && (i_addr == r_addr1);
        end
        r_addr1    <= i_addr;
        r_fwd_data <= wr_word;
    end

    assign rd_word = r_fwd ? r_fwd_data : ram_q;
    assign up_cls  = rd_word[3:2];
    assign mid_cls = rd_word[1:0];
    assign wr_word = {mid_cls, r_s1.cls};

    // Shift the window along by one pixel per push
    always_ff @(posedge i_clk) begin
        if (r_s1.push) begin
            r_v1 <= r_s1.cls;
            r_m1 <= mid_cls;
            r_m2 <= r_m1;
            r_u1 <= up_cls;
        end
    end

    // Single-row frames lag by one row only
    assign cur_cls = r_s1.h_one ? mid_cls : r_m1;

    always_comb begin
        o_res.col  = r_s1.col;
        o_res.row  = r_s1.row;
        o_res.last = r_s1.last;
        o_res.bnd  = (cur_cls != CLS_ZERO) &&
                     (r_s1.on_rim || (mid_cls != CLS_ONE) || (r_m2 != CLS_ONE) ||
                      (r_v1 != CLS_ONE) || (r_u1 != CLS_ONE));
    end

    assign o_res_vld = r_s1.emit;
    assign o_pend    = r_s1.emit;

endmodule

@@ sv/mbd_outq.sv @@
module mbd_outq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  mbd_pkg::t_result               i_data,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output mbd_pkg::t_result               o_data,
    output logic [mbd_pkg::OQ_CNT_W-1:0]   o_count
);

    import mbd_pkg::*;

    t_result             r_data [OQ_DEPTH];
    logic [OQ_AW-1:0]    r_wp;
    logic [OQ_AW-1:0]    r_rp;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic                pop;

    assign o_tvalid = (r_cnt != '0);
    assign pop      = o_tvalid && i_tready;
    assign o_data   = r_data[r_rp];
    assign o_count  = r_cnt;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + OQ_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + OQ_AW'(1);
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + OQ_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - OQ_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end

endmodule

@@ sv/mask_boundary_detect.sv @@
// Path: a decision goes via the stage 1 register and the output queue to m_axis
//   after the accept completing it (the pixel a row and a pixel on, or a drain step).
// Throughput: one transaction per cycle, set by one line buffer read and one
//   write-back per pixel; the 4-entry output queue absorbs stalls until it fills.
// Reset: position counters cleared, frame size back to 640 x 480 (clamped to the
//   maximums); the line buffer is not cleared, stale columns only feed rim pixels.
module mask_boundary_detect #(
    parameter int MAX_WIDTH  = mbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mbd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mbd_pkg::CFG_W-1:0]       i_cfg_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mbd_pkg::LABEL_W-1:0]     s_axis_tdata,  // [7:0] label
    input  logic                            s_axis_tuser,  // [0] operation
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mbd_pkg::M_DATA_W-1:0]    m_axis_tdata,  // [9:0] col, [19:10] row,
                                                           // [20] is_boundary, zero above
    output logic                            m_axis_tlast   // frame_last
);

    import mbd_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    function automatic logic [WW-1:0] clamp_w(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return WW'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            return WW'(MAX_WIDTH);
        end
        return WW'(v);
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return HW'(1);
        end else if (int'(v) > MAX_HEIGHT) begin
            return HW'(MAX_HEIGHT);
        end
        return HW'(v);
    endfunction

    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;
    logic [CW-1:0] r_in_col,  n_in_col;
    logic [HW-1:0] r_in_row,  n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;

    logic          acc;
    logic          full;
    logic          pix;
    logic          primed;
    logic          emit;
    logic          push;
    logic          col_end;
    logic          out_col_end;
    logic          out_row_end;
    logic          last;
    t_cls          in_cls;
    t_stage        s0;

    t_result               res;
    logic                  res_vld;
    logic                  pend;
    t_result               q_data;
    logic [OQ_CNT_W-1:0]   q_cnt;

    // Credit: room for the queue contents, the stage 1 result and one more
    assign s_axis_tready = ({1'b0, q_cnt} + (OQ_CNT_W + 1)'(pend)) < (OQ_CNT_W + 1)'(OQ_DEPTH);
    assign acc           = s_axis_tvalid && s_axis_tready;

    // Label class of the incoming pixel
    always_comb begin
        if (s_axis_tdata == LABEL_W'(0)) begin
            in_cls = CLS_ZERO;
        end else if (s_axis_tdata == LABEL_W'(1)) begin
            in_cls = CLS_ONE;
        end else begin
            in_cls = CLS_OTHER;
        end
    end

    // Stage 0: position bookkeeping and emit decision
    assign full        = (r_in_row >= r_h);
    assign pix         = !s_axis_tuser && !full;
    assign primed      = (r_in_row >= HW'(2)) || ((r_in_row == HW'(1)) && (r_in_col != '0));
    assign emit        = pix ? primed : full;
    assign push        = pix || full;
    assign col_end     = (WW'(r_in_col) == (r_w - WW'(1)));
    assign out_col_end = (WW'(r_out_col) == (r_w - WW'(1)));
    assign out_row_end = (HW'(r_out_row) == (r_h - HW'(1)));
    assign last        = emit && out_row_end && out_col_end;

    always_comb begin
        s0.push   = acc && push;
        s0.emit   = acc && emit;
        s0.last   = last;
        s0.on_rim = (r_out_row == '0) || out_row_end || (r_out_col == '0) || out_col_end;
        s0.h_one  = (r_h == HW'(1));
        s0.cls    = pix ? in_cls : CLS_ZERO;
        s0.col    = COL_O_W'(r_out_col);
        s0.row    = ROW_O_W'(r_out_row);
    end

    // Next positions; the column keeps cycling through drain steps
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_cfg_we || (s0.push && last)) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (s0.push) begin
            n_in_col = col_end ? '0 : r_in_col + CW'(1);
            if (pix && col_end) begin
                n_in_row = r_in_row + HW'(1);
            end
            if (emit) begin
                n_out_col = out_col_end ? '0 : r_out_col + CW'(1);
                if (out_col_end) begin
                    n_out_row = r_out_row + RW'(1);
                end
            end
        end
    end

    // Counters and frame size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= clamp_w(FRAME_WIDTH_RST);
            r_h       <= clamp_h(FRAME_HEIGHT_RST);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FRAME_WIDTH:  r_w <= clamp_w(i_cfg_data);
                    REG_FRAME_HEIGHT: r_h <= clamp_h(i_cfg_data);
                    default:          r_w <= r_w;
                endcase
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // Stage 1: line buffer and neighbour window
    mbd_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s0      (s0),
        .i_addr    (r_in_col),
        .o_res     (res),
        .o_res_vld (res_vld),
        .o_pend    (pend)
    );

    // Output queue
    mbd_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_vld),
        .i_data   (res),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_data   (q_data),
        .o_count  (q_cnt)
    );

    assign m_axis_tdata = {(M_DATA_W - COL_O_W - ROW_O_W - 1)'(0), q_data.bnd,
                           q_data.row, q_data.col};
    assign m_axis_tlast = q_data.last;

endmodule

@@ sv/mbd_checker.sv @@
module mbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic       out_acc;
    logic [9:0] col;
    logic [9:0] row;
    logic       r_start;
    logic       r_prev_vld;
    logic [9:0] r_pc;
    logic [9:0] r_pr;

    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign col     = m_axis_tdata[9:0];
    assign row     = m_axis_tdata[19:10];

    // Track the position of the last decision taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= 1'b1;
            r_prev_vld <= 1'b0;
        end else if (i_cfg_we || (out_acc && m_axis_tlast)) begin
            r_start    <= 1'b1;
            r_prev_vld <= 1'b0;
        end else if (out_acc) begin
            r_start    <= 1'b0;
            r_prev_vld <= 1'b1;
        end
        if (out_acc) begin
            r_pc <= col;
            r_pr <= row;
        end
    end

    // A stalled decision holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // An empty output queue never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output empty");

    // Each frame starts at the origin
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_start |-> (col == 10'd0) && (row == 10'd0))
        else $error("frame did not start at origin");

    // Decisions follow raster order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_prev_vld |->
            ((col == 10'(r_pc + 10'd1)) && (row == r_pr)) ||
            ((col == 10'd0) && (row == 10'(r_pr + 10'd1))))
        else $error("decision out of raster order");

endmodule

bind mask_boundary_detect mbd_checker u_mbd_checker (.*);
